// ===== src/fta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_pkg: shared types and constants for the Q16.16 to decimal text converter
// Digit counts, character codes, the reciprocal used for divide-by-ten and
// the record that travels from the digit converter to the character emitter.
// ----------------------------------------------------------------------------
package fta_pkg;

  // Integer part is 16 bits, so at most five decimal digits.
  localparam int IntDigits  = 5;
  localparam int FracDigits = 3;

  function automatic int pow10(input int n);
    int p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam int Pow10    = pow10(FracDigits);
  localparam int FdW      = $clog2(Pow10);
  localparam int NumDig   = IntDigits + FracDigits;
  localparam int DigW     = $clog2(NumDig);
  localparam int MaxChars = NumDig + 1;
  localparam int KW       = $clog2(MaxChars);
  localparam int CntW     = $clog2(IntDigits + 1);

  // x / 10 == (x * 52429) >> 19 for every 16-bit x.
  localparam logic [15:0] RecipMul   = 16'd52429;
  localparam int          RecipShift = 19;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharDot  = 8'h2E;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } front_state_e;

  // Digits 0..IntDigits-1: integer part, least significant first.
  // Digits IntDigits..NumDig-1: fraction digits, least significant first.
  typedef struct packed {
    logic [NumDig-1:0][3:0] digs;
    logic [CntW-1:0]        n_int;
  } fta_rec_t;

endpackage

// ===== src/fta_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_front: input stage and digit converter
// Accepts one Q16.16 value, scales the fraction, then splits both parts into
// decimal digits with one shared divide-by-ten step per cycle.
// ----------------------------------------------------------------------------
module fta_front import fta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  logic [31:0] value_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output fta_rec_t q_rec_o
);

  front_state_e state_q, state_d;

  logic [15:0]       w_q, w_d;
  logic [FdW-1:0]    f_q;
  logic [DigW-1:0]   step_q;
  logic [3:0]        digs_q [NumDig];

  logic              accept;
  logic [16+FdW-1:0] prod;
  logic [FdW-1:0]    fd;
  logic [31:0]       m;
  logic [12:0]       q;
  logic [15:0]       r;
  logic              last_step;
  logic [CntW-1:0]   n_int;

  // Fraction scaling: floor(f * 10^FracDigits / 65536).
  always_comb begin
    prod = {{FdW{1'b0}}, value_i[15:0]} * (16 + FdW)'(Pow10);
    fd   = prod[16+FdW-1:16];
  end

  // One divide-by-ten step on the working value.
  always_comb begin
    m = {16'd0, w_q} * {16'd0, RecipMul};
    q = m[RecipShift+12:RecipShift];
    r = w_q - (({3'd0, q} << 3) + ({3'd0, q} << 1));
  end

  assign last_step = (step_q == DigW'(NumDig - 1));

  always_comb begin
    if (step_q == DigW'(IntDigits - 1)) begin
      w_d = 16'(f_q);
    end else begin
      w_d = {3'd0, q};
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: begin
        if (accept) state_d = FE_CONV;
      end
      FE_CONV: begin
        if (last_step) state_d = FE_PUSH;
      end
      FE_PUSH: begin
        if (!q_full_i) state_d = accept ? FE_CONV : FE_IDLE;
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    full     = 1'b1;
    q_push_o = 1'b0;
    unique case (state_q)
      FE_IDLE: full = 1'b0;
      FE_CONV: full = 1'b1;
      FE_PUSH: begin
        q_push_o = !q_full_i;
        full     = q_full_i;
      end
      default: full = 1'b1;
    endcase
  end

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q    <= value_i[31:16];
      f_q    <= fd;
      step_q <= '0;
    end else if (state_q == FE_CONV) begin
      digs_q[step_q] <= r[3:0];
      w_q            <= w_d;
      step_q         <= step_q + DigW'(1);
    end
  end

  // Integer digit count: highest nonzero digit, at least one.
  always_comb begin
    n_int = CntW'(1);
    for (int i = 0; i < IntDigits; i++) begin
      if (digs_q[i] != 4'd0) n_int = CntW'(i + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      q_rec_o.digs[i] = digs_q[i];
    end
    q_rec_o.n_int = n_int;
  end

endmodule

// ===== src/fta_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_fifo: short record queue between converter and emitter
// Holds converted digit records so each side can stall on its own.
// ----------------------------------------------------------------------------
module fta_fifo import fta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fta_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output fta_rec_t rec_o,
  output logic     empty_o
);

  fta_rec_t          ent_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QPtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (QPtrW + 1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + QPtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= rec_i;
  end

endmodule

// ===== src/fta_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_back: character emitter
// Walks the head record one character per transfer: integer digits most
// significant first, the separator, then the zero-padded fraction digits.
// ----------------------------------------------------------------------------
module fta_back import fta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fta_rec_t   rec_i,
  input  logic       q_empty_i,
  output logic       q_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] text_char_o,
  output logic       last_o
);

  logic [KW-1:0]   k_q;
  logic [KW-1:0]   n_int;
  logic [KW-1:0]   total_m1;
  logic [KW-1:0]   idx_full;
  logic [DigW-1:0] idx;
  logic            take;

  assign n_int    = KW'(rec_i.n_int);
  assign total_m1 = n_int + KW'(FracDigits);
  assign last_o   = (k_q == total_m1);
  assign empty    = q_empty_i;
  assign take     = pop && !q_empty_i;
  assign q_pop_o  = take && last_o;

  always_comb begin
    if (k_q < n_int) begin
      idx_full = n_int - KW'(1) - k_q;
    end else begin
      idx_full = KW'(IntDigits) + total_m1 - k_q;
    end
    idx = idx_full[DigW-1:0];
    if (k_q == n_int) begin
      text_char_o = CharDot;
    end else begin
      text_char_o = CharZero + {4'd0, rec_i.digs[idx]};
    end
  end

  // Advance through the record; drop it after its final character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (take) begin
      k_q <= last_o ? '0 : k_q + KW'(1);
    end
  end

endmodule

// ===== src/fixed_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii: unsigned Q16.16 to decimal ASCII text
// Each accepted value leaves as a run of characters: integer digits without
// leading zeros (a zero part gives one '0'), '.', then three fraction digits
// floor(frac * 1000 / 65536), zero-padded. The final character flags last.
// ----------------------------------------------------------------------------
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   input    | push / full        | value_i[31:0]
//   result   | pop / empty        | text_char_o[7:0], last_o
//
// Flow: after a value is taken the converter runs eight shared
// divide-by-ten steps, one per cycle, then hands the record over in its push
// state, which also takes the next value; no value is taken mid-conversion.
// The emitter sends one character per cycle while pop is high and a record
// is queued, five to nine per value, and overlaps the next conversion.
// Reset (rst_ni low) empties the record queue and returns both sides to idle.
// Stalls: a held pop stalls the emitter; a full queue stalls the converter,
// which keeps full high until its record is stored.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii import fta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  text_char_o,
  output logic        last_o
);

  // Record path between converter and emitter.
  fta_rec_t front_rec;
  fta_rec_t head_rec;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  // Front: take a value and split it into decimal digits.
  fta_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .value_i  (value_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_rec_o  (front_rec)
  );

  // Hold finished records until the emitter gets to them.
  fta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rec_o   (head_rec),
    .empty_o (q_empty)
  );

  // Back: one character per result transfer.
  fta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (head_rec),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Q16.16 to decimal text converter
// Values go in through the push/full side and characters are drained through
// the pop/empty side. A directed table walks the field extremes, every digit
// count and the fraction rounding edges. Random values follow, with traffic
// gaps on both sides, one long receiver stall and one full drain. Every
// character and its last flag is checked in order against typed text or a local predictor.
// ----------------------------------------------------------------------------
module tb_top import fta_pkg::*; ();

  localparam int RandomValues = 255;
  localparam int CycleLimit   = 200000;
  localparam int IdlePercent  = 36;
  localparam int StallCycles  = 150;

  // One expected character and whether it closes the number's text.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push;
  logic        full;
  logic [31:0] value_i;
  logic        empty;
  logic        pop;
  logic [7:0]  text_char_o;
  logic        last_o;

  text_char_t  expected_text [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // Text typed in for the row being offered; empty means use the predictor.
  string       offered_text = "";
  // Sender-owned hints that steer the receiver: no idling, and one long stall.
  logic        steady_mode = 1'b0;
  logic        stall_request = 1'b0;

  // Directed rows: extremes, each integer digit count, fraction edges.
  logic [31:0] dir_value [25] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
    32'h0000_FFFF, 32'h0000_0001, 32'h0000_0041, 32'h0000_0042, 32'h0000_028F,
    32'h0000_0290, 32'h0000_1999, 32'h0000_199A, 32'h0009_0000, 32'h000A_0000,
    32'h0063_0000, 32'h0064_0000, 32'h03E7_0000, 32'h03E8_0000, 32'h270F_0000,
    32'h2710_0000, 32'hFFFF_0000, 32'h3039_C000, 32'hAAAA_5555, 32'h5555_AAAA
  };
  string dir_text [25] = '{
    "0.000", "65535.999", "1.000", "0.500", "0.250",
    "0.999", "0.000", "0.000", "0.001", "0.009",
    "0.010", "0.099", "0.100", "9.000", "10.000",
    "99.000", "100.000", "999.000", "1000.000", "9999.000",
    "10000.000", "65535.000", "", "", ""
  };

  fixed_to_decimal_ascii uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .empty       (empty),
    .pop         (pop),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Hold reset low, then release it on a falling edge.
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Expand one value into its characters: integer digits without leading
  // zeros, the separator, then the truncated fraction digits, zero-padded.
  function automatic void expand_to_text(input logic [31:0] v);
    logic [15:0] ip;
    logic [31:0] frac_scale;
    logic [31:0] fd;
    logic [3:0]  idig [8];
    logic [3:0]  fdig [8];
    int          n;
    text_char_t  tc;
    frac_scale = 32'd1;
    for (int k = 0; k < FracDigits; k++) frac_scale = frac_scale * 32'd10;
    fd = (32'(v[15:0]) * frac_scale) >> 16;
    ip = v[31:16];
    n = 0;
    do begin
      idig[n] = 4'(ip % 16'd10);
      ip = ip / 16'd10;
      n++;
    end while (ip != 16'd0);
    for (int k = n - 1; k >= 0; k--) begin
      tc.ch = CharZero + 8'(idig[k]);
      tc.last = 1'b0;
      expected_text.push_back(tc);
    end
    tc.ch = CharDot;
    tc.last = 1'b0;
    expected_text.push_back(tc);
    for (int k = 0; k < FracDigits; k++) begin
      fdig[k] = 4'(fd % 32'd10);
      fd = fd / 32'd10;
    end
    for (int k = FracDigits - 1; k >= 0; k--) begin
      tc.ch = CharZero + 8'(fdig[k]);
      tc.last = (k == 0);
      expected_text.push_back(tc);
    end
  endfunction

  // Queue text typed straight into the table; the final character is last.
  function automatic void load_typed_text(input string s);
    text_char_t tc;
    for (int k = 0; k < s.len(); k++) begin
      tc.ch = 8'(s[k]);
      tc.last = (k == s.len() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  // Mixed magnitudes so every integer digit count shows up often.
  function automatic logic [31:0] pick_value();
    logic [15:0] ip;
    logic [15:0] fp;
    fp = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0:       ip = 16'd0;
      1:       ip = 16'($urandom_range(1, 9));
      2:       ip = 16'($urandom_range(10, 99));
      3:       ip = 16'($urandom_range(100, 999));
      4:       ip = 16'($urandom_range(1000, 9999));
      5:       ip = 16'($urandom_range(10000, 65535));
      6: begin
        ip = 16'hFFFF;
        fp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      default: return $urandom;
    endcase
    return {ip, fp};
  endfunction

  // Check each popped character against the oldest expectation, then queue
  // the text of any value accepted at this edge. Results lag acceptance, so
  // the order of the two within the edge never matters.
  always @(posedge clk_i) begin
    text_char_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && pop && !empty) begin
      if (expected_text.size() == 0) begin
        mismatch_count++;
        $display("%0t: char expected none, actual char 8'h%02h last %0b",
                 $time, text_char_o, last_o);
      end else begin
        want = expected_text.pop_front();
        if (text_char_o !== want.ch || last_o !== want.last) begin
          mismatch_count++;
          $display("%0t: char expected 8'h%02h last %0b, actual 8'h%02h last %0b",
                   $time, want.ch, want.last, text_char_o, last_o);
        end
      end
    end
    if (rst_ni && push && !full) begin
      if (offered_text.len() != 0) load_typed_text(offered_text);
      else expand_to_text(value_i);
    end
  end

  // Offer one value, entered at a falling edge. Each cycle idle at random
  // unless in steady mode, otherwise drive push high with the value; leave at
  // the falling edge after the transfer with push still high so back-to-back
  // offers work.
  task automatic offer(input logic [31:0] v, input string txt);
    logic done;
    done = 1'b0;
    offered_text = txt;
    while (!done) begin
      if (!steady_mode && $urandom_range(0, 99) < IdlePercent) begin
        push <= 1'b0;
        value_i <= $urandom;
      end else begin
        push <= 1'b1;
        value_i <= v;
      end
      @(posedge clk_i);
      done = push && !full;
      @(negedge clk_i);
    end
  endtask

  // Drop push and wait until every queued character has been drained.
  task automatic drain_all();
    push <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender: directed table, a full drain, then random values.
  initial begin
    push = 1'b0;
    value_i = 32'd0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    for (int i = 0; i < 25; i++) offer(dir_value[i], dir_text[i]);
    drain_all();
    for (int i = 0; i < RandomValues; i++) begin
      // Ask the receiver for one long stall while offers keep coming.
      if (i == 40) stall_request = 1'b1;
      steady_mode = (i >= 120 && i < 180);
      if (i == 200) drain_all();
      offer(pick_value(), "");
    end
    push <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
    // Keep watching for stray characters before the final verdict.
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: pop at random, always in steady mode, and hold off once for a
  // long stretch so the record queue fills and full backs up the sender.
  initial begin
    int  stall_left;
    logic stall_done;
    pop = 1'b0;
    stall_left = 0;
    stall_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        stall_left = StallCycles - 1;
        pop <= 1'b0;
      end else begin
        pop <= steady_mode || ($urandom_range(0, 99) >= IdlePercent);
      end
    end
  end

endmodule

// ===== fixed_to_decimal_ascii.f =====
src/fta_pkg.sv
src/fta_front.sv
src/fta_fifo.sv
src/fta_back.sv
src/fixed_to_decimal_ascii.sv
sim/tb_top.sv
